// ----- sv/can_rx_filter_error_confinement_defines.svh -----
// Assertion macros shared by the receive filter block.
`ifndef CAN_RX_FILTER_ERROR_CONFINEMENT_DEFINES_SVH
`define CAN_RX_FILTER_ERROR_CONFINEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CRF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/can_rxf_pkg.sv -----
`default_nettype none
package can_rxf_pkg;

    localparam int ID_W       = 29;
    localparam int CFG_DATA_W = 59;
    localparam int CFG_IDX_W  = 4;
    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 8;

    localparam logic [CNT_W-1:0] ERR_SAT       = 8'd255;
    localparam logic [CNT_W-1:0] PASSIVE_LIMIT = 8'd128;
    localparam logic [CNT_W-1:0] CNT_STEP      = 8'h01;

    // Event codes carried in the input user field.
    typedef enum logic [1:0] {
        OP_FRAME    = 2'd0,
        OP_TX_ERROR = 2'd1,
        OP_RECOVER  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_DATA  = 2'd1,
        CLASS_ERROR = 2'd2
    } frame_class_t;

    typedef enum logic [1:0] {
        NODE_ACTIVE  = 2'd0,
        NODE_PASSIVE = 2'd1,
        NODE_BUS_OFF = 2'd2
    } node_state_t;

    // One filter register: enable, match id, mask.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] match_id;
        logic [ID_W-1:0] mask;
    } filter_t;

    // Event handed from the input stage to the core.
    typedef struct packed {
        op_t  op;
        logic error_frame;
        logic matched;
    } item_t;

    // Result data word, lowest field in the lowest bits.
    typedef struct packed {
        logic              pad;
        logic              tx_allowed;
        node_state_t       node_state;
        logic [CNT_W-1:0]  rx_errors;
        logic [CNT_W-1:0]  tx_errors;
        logic [12:0]       log_count;
        logic [11:0]       log_slot;
        logic              rx_overflow;
        logic [8:0]        rx_count;
        logic [7:0]        rx_slot;
        logic [SEQ_W-1:0]  sequence_res;
        logic              accepted;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/can_rx_filter_error_confinement.sv -----
`default_nettype none
// CAN receive acceptance filter with error confinement. Each transfer on the
// s_ side is one event: a received frame, a transmit bus error or a bus-off
// recovery request; each yields exactly one result transfer on the m_ side.
// The block takes one event per clock cycle unless a stalled result holds the
// flow; an event goes from the s_ transfer into the input register and then
// into the result register, which drives m_tvalid, with the filter compare and
// the counter update between them. A stalled result holds in the result
// register while one more event waits in the input register. Filters must be
// written through cfg_we/cfg_index/cfg_wdata only while no event is in flight;
// the block itself does not enforce this. Indexes at or beyond NUM_FILTERS are ignored.
module can_rx_filter_error_confinement #(
    parameter int NUM_FILTERS = 8,
    parameter int RX_DEPTH    = 256,
    parameter int LOG_DEPTH   = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // frame_id[28:0], zero pad
    input  wire logic [2:0]  s_tuser,   // op[1:0], frame_is_error[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // accepted[0], sequence_res[32:1], rx_slot[40:33],
                                        // rx_count[49:41], rx_overflow[50],
                                        // log_slot[62:51], log_count[75:63],
                                        // tx_errors[83:76], rx_errors[91:84],
                                        // node_state[93:92], tx_allowed[94], pad[95]
    output logic [1:0]       m_tuser,   // frame_class[1:0]
    input  wire logic        cfg_we,
    input  wire logic [can_rxf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [can_rxf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                             in_valid_reg;
    logic                             in_valid_next;
    can_rxf_pkg::op_t                 op_reg;
    logic [can_rxf_pkg::ID_W-1:0]     id_reg;
    logic                             err_reg;
    logic                             matched;
    logic                             in_take;
    can_rxf_pkg::item_t               item;
    can_rxf_pkg::result_t             m_data;
    can_rxf_pkg::frame_class_t        m_class;

    // Accept when the input register is empty or moving on this cycle
    assign s_tready = !in_valid_reg || in_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the event payload on each input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= can_rxf_pkg::op_t'(s_tuser[1:0]);
            id_reg  <= s_tdata[can_rxf_pkg::ID_W-1:0];
            err_reg <= s_tuser[2];
        end
    end

    can_rxf_filter #(
        .NUM_FILTERS(NUM_FILTERS)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame_id  (id_reg),
        .matched   (matched)
    );

    assign item = '{op: op_reg, error_frame: err_reg, matched: matched};

    can_rxf_core #(
        .RX_DEPTH  (RX_DEPTH),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .item     (item),
        .in_take  (in_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_data),
        .m_class  (m_class)
    );

    assign m_tdata = m_data;
    assign m_tuser = m_class;

endmodule
`default_nettype wire

// ----- sv/can_rxf_filter.sv -----
`default_nettype none
module can_rxf_filter #(
    parameter int NUM_FILTERS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [can_rxf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [can_rxf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [can_rxf_pkg::ID_W-1:0]       frame_id,
    output logic                                    matched
);

    can_rxf_pkg::filter_t filt_reg [NUM_FILTERS];
    logic [NUM_FILTERS-1:0] hit;

    // Store filter registers; writes to absent filters fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_FILTERS; k++) begin
                filt_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            for (int k = 0; k < NUM_FILTERS; k++) begin
                if (cfg_index == can_rxf_pkg::CFG_IDX_W'(k)) begin
                    filt_reg[k] <= can_rxf_pkg::filter_t'(cfg_wdata);
                end
            end
        end
    end

    // Compare all filters in parallel
    always_comb begin
        for (int k = 0; k < NUM_FILTERS; k++) begin
            hit[k] = filt_reg[k].en &&
                     (((frame_id ^ filt_reg[k].match_id) & filt_reg[k].mask) == '0);
        end
    end

    assign matched = |hit;

endmodule
`default_nettype wire

// ----- sv/can_rxf_core.sv -----
`default_nettype none
`include "can_rx_filter_error_confinement_defines.svh"
module can_rxf_core #(
    parameter int RX_DEPTH  = 256,
    parameter int LOG_DEPTH = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire can_rxf_pkg::item_t    item,
    output logic                       in_take,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output can_rxf_pkg::result_t       m_data,
    output can_rxf_pkg::frame_class_t  m_class
);

    localparam int RX_PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int LG_PTR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LG_FILL_W = $clog2(LOG_DEPTH + 1);

    localparam logic [RX_PTR_W-1:0]  RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [RX_FILL_W-1:0] RX_FULL = RX_FILL_W'(RX_DEPTH);
    localparam logic [LG_PTR_W-1:0]  LG_LAST = LG_PTR_W'(LOG_DEPTH - 1);
    localparam logic [LG_FILL_W-1:0] LG_FULL = LG_FILL_W'(LOG_DEPTH);

    logic [can_rxf_pkg::CNT_W-1:0] tx_err_reg, tx_err_next;
    logic [can_rxf_pkg::CNT_W-1:0] rx_err_reg, rx_err_next;
    can_rxf_pkg::node_state_t      fault_reg, fault_next;
    logic [can_rxf_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [RX_PTR_W-1:0]           ring_head_reg, ring_head_next;
    logic [RX_FILL_W-1:0]          ring_fill_reg, ring_fill_next;
    logic                          ring_ovf_reg, ring_ovf_next;
    logic [LG_PTR_W-1:0]           log_head_reg, log_head_next;
    logic [LG_FILL_W-1:0]          log_fill_reg, log_fill_next;

    logic                          out_valid_reg;
    can_rxf_pkg::result_t          res_reg, res_next;
    can_rxf_pkg::frame_class_t     class_reg, class_next;

    logic                          acc;
    logic                          log_it;
    logic [31:0]                   rx_slot_w, rx_fill_w, log_slot_w, log_fill_w;

    function automatic can_rxf_pkg::node_state_t node_of(
        input logic [can_rxf_pkg::CNT_W-1:0] tx_c,
        input logic [can_rxf_pkg::CNT_W-1:0] rx_c
    );
        if (tx_c >= can_rxf_pkg::ERR_SAT) begin
            return can_rxf_pkg::NODE_BUS_OFF;
        end else if (tx_c >= can_rxf_pkg::PASSIVE_LIMIT ||
                     rx_c >= can_rxf_pkg::PASSIVE_LIMIT) begin
            return can_rxf_pkg::NODE_PASSIVE;
        end
        return can_rxf_pkg::NODE_ACTIVE;
    endfunction

    // Advance when the result register is free or being drained
    assign in_take = in_valid && (!out_valid_reg || m_ready);

    // Work out the next state for the event at the core input
    always_comb begin
        tx_err_next    = tx_err_reg;
        rx_err_next    = rx_err_reg;
        fault_next     = fault_reg;
        seq_next       = seq_reg;
        ring_head_next = ring_head_reg;
        ring_fill_next = ring_fill_reg;
        ring_ovf_next  = ring_ovf_reg;
        log_head_next  = log_head_reg;
        log_fill_next  = log_fill_reg;
        acc            = 1'b0;
        log_it         = 1'b0;
        class_next     = can_rxf_pkg::CLASS_NONE;
        rx_slot_w      = '0;
        log_slot_w     = '0;

        unique case (item.op)
            can_rxf_pkg::OP_FRAME: begin
                if (item.matched) begin
                    acc      = 1'b1;
                    log_it   = 1'b1;
                    seq_next = seq_reg + 32'd1;
                    if (item.error_frame) begin
                        class_next = can_rxf_pkg::CLASS_ERROR;
                        if (rx_err_reg < can_rxf_pkg::ERR_SAT) begin
                            rx_err_next = rx_err_reg + can_rxf_pkg::CNT_STEP;
                        end
                        fault_next = node_of(tx_err_reg, rx_err_next);
                    end else begin
                        class_next     = can_rxf_pkg::CLASS_DATA;
                        rx_slot_w      = 32'(ring_head_reg);
                        ring_head_next = (ring_head_reg == RX_LAST) ? '0 :
                                         ring_head_reg + RX_PTR_W'(1);
                        if (ring_fill_reg >= RX_FULL) begin
                            ring_ovf_next = 1'b1;
                        end else begin
                            ring_fill_next = ring_fill_reg + RX_FILL_W'(1);
                        end
                    end
                end
            end
            can_rxf_pkg::OP_TX_ERROR: begin
                if (tx_err_reg < can_rxf_pkg::ERR_SAT) begin
                    tx_err_next = tx_err_reg + can_rxf_pkg::CNT_STEP;
                end
                fault_next = node_of(tx_err_next, rx_err_reg);
            end
            can_rxf_pkg::OP_RECOVER: begin
                if (fault_reg == can_rxf_pkg::NODE_BUS_OFF) begin
                    tx_err_next = '0;
                    rx_err_next = '0;
                    fault_next  = can_rxf_pkg::NODE_ACTIVE;
                end
            end
            default: ;
        endcase

        // Log every accepted frame
        if (log_it) begin
            log_slot_w    = 32'(log_head_reg);
            log_head_next = (log_head_reg == LG_LAST) ? '0 : log_head_reg + LG_PTR_W'(1);
            if (log_fill_reg < LG_FULL) begin
                log_fill_next = log_fill_reg + LG_FILL_W'(1);
            end
        end
    end

    // Assemble the result word
    always_comb begin
        rx_fill_w  = 32'(ring_fill_next);
        log_fill_w = 32'(log_fill_next);
        res_next              = '0;
        res_next.accepted     = acc;
        res_next.sequence_res = acc ? seq_reg : '0;
        res_next.rx_slot      = rx_slot_w[7:0];
        res_next.rx_count     = rx_fill_w[8:0];
        res_next.rx_overflow  = ring_ovf_next;
        res_next.log_slot     = log_slot_w[11:0];
        res_next.log_count    = log_fill_w[12:0];
        res_next.tx_errors    = tx_err_next;
        res_next.rx_errors    = rx_err_next;
        res_next.node_state   = fault_next;
        res_next.tx_allowed   = (fault_next == can_rxf_pkg::NODE_ACTIVE);
    end

    // Commit state on each transfer into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_err_reg    <= '0;
            rx_err_reg    <= '0;
            fault_reg     <= can_rxf_pkg::NODE_ACTIVE;
            seq_reg       <= '0;
            ring_head_reg <= '0;
            ring_fill_reg <= '0;
            ring_ovf_reg  <= 1'b0;
            log_head_reg  <= '0;
            log_fill_reg  <= '0;
        end else if (in_take) begin
            tx_err_reg    <= tx_err_next;
            rx_err_reg    <= rx_err_next;
            fault_reg     <= fault_next;
            seq_reg       <= seq_next;
            ring_head_reg <= ring_head_next;
            ring_fill_reg <= ring_fill_next;
            ring_ovf_reg  <= ring_ovf_next;
            log_head_reg  <= log_head_next;
            log_fill_reg  <= log_fill_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg   <= res_next;
            class_reg <= class_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = res_reg;
    assign m_class = class_reg;

    `CRF_ASSERT_SAME(a_busoff_sat, aclk, aresetn,
        fault_reg == can_rxf_pkg::NODE_BUS_OFF, tx_err_reg == can_rxf_pkg::ERR_SAT,
        "bus off without saturated transmit counter")
    `CRF_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, ring_fill_reg <= RX_FULL,
        "receive ring fill above depth")
    `CRF_ASSERT_NEXT(a_seq_step, aclk, aresetn, in_take && acc,
        seq_reg == $past(seq_reg) + 32'd1, "sequence number did not advance")
    `CRF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, out_valid_reg && !m_ready,
        out_valid_reg && res_reg == $past(res_reg), "stalled result lost")

endmodule
`default_nettype wire
